[sv/pts_pkg.sv]
// Package for the priority task scheduler: sizes, operation codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package pts_pkg;

  localparam int NUM_TASKS = 16;
  localparam int NUM_PRIO  = 32;
  localparam int TASK_W    = 4;
  localparam int PRIO_W    = 5;

  localparam logic [7:0] LOCK_MAX    = 8'd255;
  localparam logic [7:0] SLICE_RESET = 8'd10;

  typedef enum logic [2:0] {
    KIND_READY,
    KIND_UNREADY,
    KIND_DELAY,
    KIND_TICK,
    KIND_LOCK,
    KIND_UNLOCK,
    KIND_RESCHED,
    KIND_CANCEL
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEC,
    ST_WAKE,
    ST_SLICE,
    ST_TOP,
    ST_SCHED,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_EXEC,
    CMD_DEC,
    CMD_WAKE,
    CMD_SLICE,
    CMD_TOP,
    CMD_SCHED,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    cmd_t              op;
    logic [TASK_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  lock_one;
    logic  wake_any;
    logic  out_free;
  } dp_stat_t;

endpackage

[sv/pts_in_if.sv]
// Operation channel of the scheduler: valid/ready plus the operation fields.
// Depends on pts_pkg for field widths.
interface pts_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic [pts_pkg::TASK_W-1:0] task_id;
  logic [pts_pkg::PRIO_W-1:0] task_prio;
  logic [31:0]               delay_ticks;

  modport source (output valid, kind, task_id, task_prio, delay_ticks, input ready);
  modport sink   (input valid, kind, task_id, task_prio, delay_ticks, output ready);
endinterface

[sv/pts_out_if.sv]
// Result channel of the scheduler: valid/ready plus the result fields.
// Depends on pts_pkg for field widths.
interface pts_out_if;
  logic                      valid;
  logic                      ready;
  logic                      switch_now;
  logic [pts_pkg::TASK_W-1:0] next_task;
  logic [pts_pkg::PRIO_W-1:0] top_prio;
  logic                      none_ready;
  logic [4:0]                woke_count;
  logic [31:0]               tick_total;

  modport source (output valid, switch_now, next_task, top_prio, none_ready, woke_count,
                  tick_total, input ready);
  modport sink   (input valid, switch_now, next_task, top_prio, none_ready, woke_count,
                  tick_total, output ready);
endinterface

[sv/priority_task_scheduler_unit.sv]
// Priority task scheduler: top level joining controller and datapath.
// Depends on pts_pkg, pts_in_if, pts_out_if, pts_ctrl and pts_dp.
//
// Use: each beat on in_ch is one scheduler operation (ready, unready,
// delay, tick, lock, unlock, reschedule, cancel delay). Every operation
// yields exactly one beat on out_ch: the running task, whether it changed,
// the top ready priority, an empty flag, the wake count and the tick count.
// Write slice_length (cfg_we/cfg_wdata) only while idle; not enforced.
//
// Timing: one operation at a time. in_ch.ready is high only in the idle
// state while a beat is offered. A plain operation steps through execute,
// top pick and output; one that schedules (reschedule, tick, or the unlock
// that releases the last lock) adds a schedule step before output. A tick
// first walks the countdowns, visiting each of the 16 tasks once in turn,
// then takes one wake step per woken task, then slice, top pick, schedule.
// A next beat can be taken in the cycle after the result is registered.
//
// Reset (rst_n low, synchronous): empty queues and delay set, lock zero,
// running task 0, tick count zero, every slice and slice_length at 10.
// Receiver stall: the result waits in the output register, and the next
// operation holds in its last step until out_ch.ready lets that beat go.
module priority_task_scheduler_unit (
  input  logic       clk,
  input  logic       rst_n,
  pts_in_if.sink     in_ch,
  pts_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import pts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence the steps of each operation
  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .cmd      (cmd),
    .stat     (stat)
  );

  // hold all scheduler state and the result register
  pts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[sv/pts_ctrl.sv]
// Scheduler controller: sequences each operation through the datapath.
// Depends on pts_pkg.
module pts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output pts_pkg::dp_cmd_t  cmd,
  input  pts_pkg::dp_stat_t stat
);
  import pts_pkg::*;

  state_t            state_r, state_nxt;
  logic [TASK_W-1:0] idx_r, idx_nxt;
  logic              sched_r, sched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      sched_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      sched_r <= sched_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sched_nxt = sched_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        sched_nxt = (stat.kind == KIND_TICK) || (stat.kind == KIND_RESCHED) ||
                    ((stat.kind == KIND_UNLOCK) && stat.lock_one);
        idx_nxt   = '0;
        state_nxt = (stat.kind == KIND_TICK) ? ST_DEC : ST_TOP;
      end
      ST_DEC: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == TASK_W'(NUM_TASKS - 1)) state_nxt = ST_WAKE;
      end
      ST_WAKE: begin
        if (!stat.wake_any) state_nxt = ST_SLICE;
      end
      ST_SLICE: state_nxt = ST_TOP;
      ST_TOP:   state_nxt = sched_r ? ST_SCHED : ST_OUT;
      ST_SCHED: state_nxt = ST_OUT;
      ST_OUT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op   = CMD_NONE;
    cmd.idx  = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) cmd.op = CMD_LATCH;
      end
      ST_EXEC:  cmd.op = CMD_EXEC;
      ST_DEC:   cmd.op = CMD_DEC;
      ST_WAKE:  cmd.op = stat.wake_any ? CMD_WAKE : CMD_NONE;
      ST_SLICE: cmd.op = CMD_SLICE;
      ST_TOP:   cmd.op = CMD_TOP;
      ST_SCHED: cmd.op = CMD_SCHED;
      ST_OUT:   cmd.op = stat.out_free ? CMD_OUT : CMD_NONE;
      default:  cmd.op = CMD_NONE;
    endcase
  end

endmodule

[sv/pts_dp.sv]
// Scheduler datapath: ready set with age order, delay set with age order and
// countdowns, slices, lock depth, tick count, result register.
// Depends on pts_pkg and the two channel interfaces.
module pts_dp (
  input  logic              clk,
  input  logic              rst_n,
  pts_in_if.sink            in_ch,
  pts_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  pts_pkg::dp_cmd_t  cmd,
  output pts_pkg::dp_stat_t stat
);
  import pts_pkg::*;

  // latched operation
  kind_t             kind_r;
  logic [TASK_W-1:0] tid_r;
  logic [PRIO_W-1:0] tprio_r;
  logic [31:0]       dticks_r;

  // task state
  logic [NUM_TASKS-1:0]              rdy_r;
  logic [PRIO_W-1:0]                 prio_r  [NUM_TASKS];
  logic [NUM_TASKS-1:0]              rage_r  [NUM_TASKS]; // rage_r[j][t]: j queued before t
  logic [NUM_TASKS-1:0]              dly_r;
  logic [NUM_TASKS-1:0]              dage_r  [NUM_TASKS];
  logic [31:0]                       dleft_r [NUM_TASKS];
  logic [NUM_TASKS-1:0]              exp_r;
  logic [7:0]                        slice_r [NUM_TASKS];
  logic [7:0]                        lock_r;
  logic [TASK_W-1:0]                 run_r;
  logic [31:0]                       ticks_r;
  logic [7:0]                        slen_r;
  logic [PRIO_W-1:0]                 top_r;
  logic                              any_r;
  logic                              sw_r;
  logic [4:0]                        woke_r;

  // result register
  logic              out_valid_r;
  logic              o_sw_r;
  logic [TASK_W-1:0] o_task_r;
  logic [PRIO_W-1:0] o_top_r;
  logic              o_none_r;
  logic [4:0]        o_woke_r;
  logic [31:0]       o_ticks_r;

  // combinational
  logic [NUM_PRIO-1:0]  bmap;
  logic [PRIO_W-1:0]    top_c;
  logic [NUM_TASKS-1:0] head_oh;
  logic [TASK_W-1:0]    head_id;
  logic                 head_any;
  logic [NUM_TASKS-1:0] wake_oh;
  logic [TASK_W-1:0]    wake_id;
  logic                 others_same;
  logic                 blk;
  logic [31:0]          dec_val;
  logic                 app_en;
  logic [TASK_W-1:0]    app_t;
  logic [PRIO_W-1:0]    app_p;
  logic                 rot_en;
  logic                 young_en;
  logic [TASK_W-1:0]    young_t;
  logic                 dq_en;
  logic                 slice_exp;

  always_comb begin
    bmap = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      if (rdy_r[t]) bmap[prio_r[t]] = 1'b1;
    end
    top_c = '0;
    for (int p = NUM_PRIO - 1; p >= 0; p--) begin
      if (bmap[p]) top_c = PRIO_W'(p);
    end

    // head of the top queue: ready there, nobody older there
    head_oh = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      blk = 1'b0;
      for (int j = 0; j < NUM_TASKS; j++) begin
        if (j != t && rdy_r[j] && prio_r[j] == prio_r[t] && rage_r[j][t]) blk = 1'b1;
      end
      head_oh[t] = rdy_r[t] && (prio_r[t] == top_r) && !blk;
    end
    head_id  = '0;
    head_any = |head_oh;
    for (int t = 0; t < NUM_TASKS; t++) begin
      if (head_oh[t]) head_id = TASK_W'(t);
    end

    // oldest expired task in delay order
    wake_oh = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      blk = 1'b0;
      for (int j = 0; j < NUM_TASKS; j++) begin
        if (j != t && exp_r[j] && dage_r[j][t]) blk = 1'b1;
      end
      wake_oh[t] = exp_r[t] && !blk;
    end
    wake_id = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      if (wake_oh[t]) wake_id = TASK_W'(t);
    end

    others_same = 1'b0;
    for (int j = 0; j < NUM_TASKS; j++) begin
      if (TASK_W'(j) != run_r && rdy_r[j] && prio_r[j] == prio_r[run_r]) others_same = 1'b1;
    end

    dec_val   = dleft_r[cmd.idx] - 32'd1;
    slice_exp = (slice_r[run_r] <= 8'd1);

    app_en = 1'b0;
    app_t  = tid_r;
    app_p  = tprio_r;
    if (cmd.op == CMD_EXEC && kind_r == KIND_READY && !rdy_r[tid_r]) begin
      app_en = 1'b1;
    end else if (cmd.op == CMD_WAKE && !rdy_r[wake_id]) begin
      app_en = 1'b1;
      app_t  = wake_id;
      app_p  = prio_r[wake_id];
    end
    rot_en   = (cmd.op == CMD_SLICE) && slice_exp && rdy_r[run_r] && others_same;
    young_en = app_en || rot_en;
    young_t  = rot_en ? run_r : app_t;
    dq_en    = (cmd.op == CMD_EXEC) && (kind_r == KIND_DELAY) && !dly_r[tid_r];
  end

  assign stat.kind     = kind_r;
  assign stat.lock_one = (lock_r == 8'd1);
  assign stat.wake_any = |exp_r;
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = (cmd.op == CMD_LATCH);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.switch_now = o_sw_r;
  assign out_ch.next_task  = o_task_r;
  assign out_ch.top_prio   = o_top_r;
  assign out_ch.none_ready = o_none_r;
  assign out_ch.woke_count = o_woke_r;
  assign out_ch.tick_total = o_ticks_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r       <= '0;
      dly_r       <= '0;
      exp_r       <= '0;
      lock_r      <= '0;
      run_r       <= '0;
      ticks_r     <= '0;
      slen_r      <= SLICE_RESET;
      sw_r        <= 1'b0;
      woke_r      <= '0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TASKS; t++) slice_r[t] <= SLICE_RESET;
    end else begin
      if (cfg_we) slen_r <= cfg_wdata;
      if (app_en) rdy_r[app_t] <= 1'b1;
      unique case (cmd.op)
        CMD_LATCH: begin
          sw_r   <= 1'b0;
          woke_r <= '0;
        end
        CMD_EXEC: begin
          unique case (kind_r)
            KIND_UNREADY: begin
              if (rdy_r[tid_r] && prio_r[tid_r] == tprio_r) rdy_r[tid_r] <= 1'b0;
            end
            KIND_DELAY:  dly_r[tid_r] <= 1'b1;
            KIND_LOCK:   if (lock_r != LOCK_MAX) lock_r <= lock_r + 8'd1;
            KIND_UNLOCK: if (lock_r != 8'd0) lock_r <= lock_r - 8'd1;
            KIND_CANCEL: dly_r[tid_r] <= 1'b0;
            default: ;
          endcase
        end
        CMD_DEC: begin
          if (dly_r[cmd.idx] && dec_val == 32'd0) begin
            dly_r[cmd.idx] <= 1'b0;
            exp_r[cmd.idx] <= 1'b1;
          end
        end
        CMD_WAKE: begin
          exp_r[wake_id] <= 1'b0;
          woke_r         <= woke_r + 5'd1;
        end
        CMD_SLICE: begin
          if (slice_exp) slice_r[run_r] <= (slen_r != 8'd0) ? slen_r : 8'd1;
          else slice_r[run_r] <= slice_r[run_r] - 8'd1;
          ticks_r <= ticks_r + 32'd1;
        end
        CMD_SCHED: begin
          if (lock_r == 8'd0 && any_r && head_any && head_id != run_r) begin
            run_r <= head_id;
            sw_r  <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd.op == CMD_OUT) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LATCH) begin
      kind_r   <= kind_t'(in_ch.kind);
      tid_r    <= in_ch.task_id;
      tprio_r  <= in_ch.task_prio;
      dticks_r <= in_ch.delay_ticks;
    end
    if (app_en) prio_r[app_t] <= app_p;
    if (young_en) begin
      for (int j = 0; j < NUM_TASKS; j++) begin
        if (TASK_W'(j) != young_t) begin
          rage_r[j][young_t] <= 1'b1;
          rage_r[young_t][j] <= 1'b0;
        end
      end
    end
    if (dq_en) begin
      for (int j = 0; j < NUM_TASKS; j++) begin
        if (TASK_W'(j) != tid_r) begin
          dage_r[j][tid_r] <= 1'b1;
          dage_r[tid_r][j] <= 1'b0;
        end
      end
    end
    if (cmd.op == CMD_EXEC && kind_r == KIND_DELAY) begin
      dleft_r[tid_r] <= (dticks_r != 32'd0) ? dticks_r : 32'd1;
    end else if (cmd.op == CMD_DEC && dly_r[cmd.idx]) begin
      dleft_r[cmd.idx] <= dec_val;
    end
    if (cmd.op == CMD_TOP) begin
      top_r <= top_c;
      any_r <= |bmap;
    end
    if (cmd.op == CMD_OUT) begin
      o_sw_r    <= sw_r;
      o_task_r  <= run_r;
      o_top_r   <= any_r ? top_r : '0;
      o_none_r  <= !any_r;
      o_woke_r  <= woke_r;
      o_ticks_r <= ticks_r;
    end
  end

endmodule

[bench/priority_task_scheduler_unit_tb.sv]
// Self-checking bench for priority_task_scheduler_unit: directed rows, then
// random operation mixes under four idling phases and several slice lengths.
// Depends on pts_pkg, pts_in_if, pts_out_if and the scheduler RTL.
`timescale 1ns / 100ps

module priority_task_scheduler_unit_tb;
  import pts_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_OPS      = 293;

  typedef struct {
    logic        switch_now;
    logic [3:0]  next_task;
    logic [4:0]  top_prio;
    logic        none_ready;
    logic [4:0]  woke_count;
    logic [31:0] tick_total;
  } sched_res_t;

  typedef struct {
    kind_t       kind;
    logic [3:0]  task_id;
    logic [4:0]  task_prio;
    logic [31:0] delay_ticks;
    bit          typed;
    sched_res_t  res;
  } op_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  priority_task_scheduler_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Expected result beats, oldest first.
  sched_res_t results_due[$];

  int errors;
  int gap_pct;
  int stall_pct;
  int idle_cycles;
  int ops_sent;
  int beats_seen;
  int wakes_seen;
  int switches_seen;

  // Scheduler shadow state: ready queues, delay list, slices, lock, ticks.
  logic [31:0] prio_map;
  logic [3:0]  q_head [32];
  logic [3:0]  q_tail [32];
  int          q_len  [32];
  logic [3:0]  r_link [16];
  logic [4:0]  t_prio [16];
  logic [31:0] d_left [16];
  logic [3:0]  d_link [16];
  logic [3:0]  dl_head, dl_tail;
  int          dl_count;
  bit          delayed [16];
  bit          queued  [16];
  bit          ever_queued [16];
  logic [7:0]  slice_left [16];
  logic [7:0]  lock_depth;
  logic [3:0]  running;
  logic [31:0] ticks;
  logic [7:0]  slice_len;

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Drive every input to a known value from time zero.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_READY;
    in_ch.task_id = '0;
    in_ch.task_prio = '0;
    in_ch.delay_ticks = '0;
    out_ch.ready = 1'b0;
  end

  function automatic void shadow_reset();
    prio_map = '0;
    for (int i = 0; i < 32; i++) begin
      q_head[i] = '0;
      q_tail[i] = '0;
      q_len[i] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      r_link[i] = '0;
      t_prio[i] = '0;
      d_left[i] = '0;
      d_link[i] = '0;
      delayed[i] = 1'b0;
      queued[i] = 1'b0;
      ever_queued[i] = 1'b0;
      slice_left[i] = SLICE_RESET;
    end
    dl_head = '0;
    dl_tail = '0;
    dl_count = 0;
    lock_depth = '0;
    running = '0;
    ticks = '0;
    slice_len = SLICE_RESET;
  endfunction

  function automatic void enqueue(logic [4:0] p, logic [3:0] t);
    if (q_len[p] == 0) q_head[p] = t;
    else r_link[q_tail[p]] = t;
    q_tail[p] = t;
    q_len[p]++;
    prio_map[p] = 1'b1;
    queued[t] = 1'b1;
    ever_queued[t] = 1'b1;
    t_prio[t] = p;
  endfunction

  // Walk the queue to find the task; a missing task changes nothing.
  function automatic void dequeue(logic [4:0] p, logic [3:0] t);
    logic [3:0] cur;
    logic [3:0] prv;
    bit has_prev;
    cur = q_head[p];
    prv = '0;
    has_prev = 1'b0;
    for (int i = 0; i < q_len[p]; i++) begin
      if (cur == t) begin
        if (has_prev) r_link[prv] = r_link[cur];
        else q_head[p] = r_link[cur];
        if (q_tail[p] == t) q_tail[p] = prv;
        q_len[p]--;
        if (q_len[p] == 0) prio_map[p] = 1'b0;
        queued[t] = 1'b0;
        return;
      end
      prv = cur;
      has_prev = 1'b1;
      cur = r_link[cur];
    end
  endfunction

  function automatic void delay_unlink(logic [3:0] t, bit has_prev, logic [3:0] prv);
    if (has_prev) d_link[prv] = d_link[t];
    else dl_head = d_link[t];
    if (dl_tail == t) dl_tail = prv;
    dl_count--;
    delayed[t] = 1'b0;
    d_left[t] = '0;
  endfunction

  function automatic void delay_drop(logic [3:0] t);
    logic [3:0] cur;
    logic [3:0] prv;
    bit has_prev;
    cur = dl_head;
    prv = '0;
    has_prev = 1'b0;
    for (int i = 0; i < dl_count; i++) begin
      if (cur == t) begin
        delay_unlink(t, has_prev, prv);
        return;
      end
      prv = cur;
      has_prev = 1'b1;
      cur = d_link[cur];
    end
  endfunction

  function automatic bit pick_task();
    if (lock_depth != 0 || prio_map == '0) return 1'b0;
    for (int p = 0; p < 32; p++) begin
      if (prio_map[p]) begin
        if (q_head[p] != running) begin
          running = q_head[p];
          return 1'b1;
        end
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  // Count the delay list down in order, wake expiries, then run the slice.
  function automatic int tick_once();
    logic [3:0] cur;
    logic [3:0] prv;
    logic [3:0] nxt;
    logic [4:0] p;
    bit has_prev;
    int n;
    int woke;
    cur = dl_head;
    prv = '0;
    has_prev = 1'b0;
    n = dl_count;
    woke = 0;
    for (int i = 0; i < n; i++) begin
      nxt = d_link[cur];
      d_left[cur] = d_left[cur] - 32'd1;
      if (d_left[cur] == '0) begin
        delay_unlink(cur, has_prev, prv);
        woke++;
        if (!queued[cur]) enqueue(t_prio[cur], cur);
      end else begin
        prv = cur;
        has_prev = 1'b1;
      end
      cur = nxt;
    end
    if (slice_left[running] <= 8'd1) begin
      p = t_prio[running];
      if (queued[running] && q_len[p] > 1) begin
        dequeue(p, running);
        enqueue(p, running);
      end
      slice_left[running] = (slice_len != 0) ? slice_len : 8'd1;
    end else begin
      slice_left[running] = slice_left[running] - 8'd1;
    end
    ticks = ticks + 32'd1;
    return woke;
  endfunction

  // Apply one operation to the shadow state and return the result beat.
  function automatic sched_res_t schedule_op(op_row_t op);
    sched_res_t r;
    r.switch_now = 1'b0;
    r.woke_count = '0;
    case (op.kind)
      KIND_READY: begin
        if (!queued[op.task_id]) enqueue(op.task_prio, op.task_id);
      end
      KIND_UNREADY: begin
        if (queued[op.task_id] && t_prio[op.task_id] == op.task_prio)
          dequeue(op.task_prio, op.task_id);
      end
      KIND_DELAY: begin
        d_left[op.task_id] = (op.delay_ticks != 0) ? op.delay_ticks : 32'd1;
        if (!delayed[op.task_id]) begin
          if (dl_count == 0) dl_head = op.task_id;
          else d_link[dl_tail] = op.task_id;
          dl_tail = op.task_id;
          dl_count++;
          delayed[op.task_id] = 1'b1;
        end
      end
      KIND_TICK: begin
        r.woke_count = 5'(tick_once());
        r.switch_now = pick_task();
      end
      KIND_LOCK: begin
        if (lock_depth < LOCK_MAX) lock_depth++;
      end
      KIND_UNLOCK: begin
        if (lock_depth > 0) begin
          lock_depth--;
          if (lock_depth == 0) r.switch_now = pick_task();
        end
      end
      KIND_RESCHED: begin
        r.switch_now = pick_task();
      end
      default: begin
        if (delayed[op.task_id]) delay_drop(op.task_id);
      end
    endcase
    r.next_task = running;
    r.none_ready = (prio_map == '0);
    r.top_prio = '0;
    for (int p = 31; p >= 0; p--)
      if (prio_map[p]) r.top_prio = 5'(p);
    r.tick_total = ticks;
    return r;
  endfunction

  // Offer one beat, holding it until accepted; idle at the sender's rate.
  task automatic send_op(op_row_t op);
    sched_res_t r;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= op.kind;
    in_ch.task_id <= op.task_id;
    in_ch.task_prio <= op.task_prio;
    in_ch.delay_ticks <= op.delay_ticks;
    do @(posedge clk); while (!in_ch.ready);
    r = schedule_op(op);
    results_due.push_back(op.typed ? op.res : r);
    ops_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // Write slice_length while idle.
  task automatic write_slice(logic [7:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    slice_len = val;
  endtask

  function automatic op_row_t mk(kind_t k, logic [3:0] t, logic [4:0] p, logic [31:0] d);
    op_row_t o;
    o.kind = k;
    o.task_id = t;
    o.task_prio = p;
    o.delay_ticks = d;
    o.typed = 1'b0;
    o.res = '{default: '0};
    return o;
  endfunction

  function automatic op_row_t mk_typed(kind_t k, logic [3:0] t, logic [4:0] p,
                                       logic sw, logic [3:0] nt, logic [4:0] tp,
                                       logic nr, logic [31:0] tt);
    op_row_t o;
    o = mk(k, t, p, '0);
    o.typed = 1'b1;
    o.res = '{switch_now: sw, next_task: nt, top_prio: tp, none_ready: nr,
              woke_count: 5'd0, tick_total: tt};
    return o;
  endfunction

  // Random operation, skewed towards well-formed use of the shadow state.
  function automatic op_row_t random_op();
    int w;
    logic [3:0] t;
    logic [4:0] p;
    logic [31:0] d;
    w = $urandom_range(99);
    t = 4'($urandom_range(15));
    p = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
    if ($urandom_range(7) == 0) d = $urandom();
    else if ($urandom_range(9) == 0) d = '0;
    else d = 32'($urandom_range(6, 1));
    if (w < 20) return mk(KIND_READY, t, p, d);
    if (w < 30) begin
      // Mostly unready with the task's real priority.
      if (queued[t] && $urandom_range(3) != 0) p = t_prio[t];
      return mk(KIND_UNREADY, t, p, d);
    end
    if (w < 45) begin
      // Never delay a task whose priority was never set.
      if (!ever_queued[t]) return mk(KIND_READY, t, p, d);
      return mk(KIND_DELAY, t, p, d);
    end
    if (w < 70) return mk(KIND_TICK, t, p, d);
    if (w < 75) return mk(KIND_LOCK, t, p, d);
    if (w < 81) return mk(KIND_UNLOCK, t, p, d);
    if (w < 91) return mk(KIND_RESCHED, t, p, d);
    return mk(KIND_CANCEL, t, p, d);
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch beat %0d: %s got %0h want %0h", beats_seen, field, got, want);
  endtask

  // Receiver: stall at the phase's rate, set at the falling edge.
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    sched_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("unexpected result beat after %0d beats", beats_seen);
      end else begin
        e = results_due.pop_front();
        if (out_ch.switch_now !== e.switch_now)
          report("switch_now", 32'(out_ch.switch_now), 32'(e.switch_now));
        if (out_ch.next_task !== e.next_task)
          report("next_task", 32'(out_ch.next_task), 32'(e.next_task));
        if (out_ch.top_prio !== e.top_prio)
          report("top_prio", 32'(out_ch.top_prio), 32'(e.top_prio));
        if (out_ch.none_ready !== e.none_ready)
          report("none_ready", 32'(out_ch.none_ready), 32'(e.none_ready));
        if (out_ch.woke_count !== e.woke_count)
          report("woke_count", 32'(out_ch.woke_count), 32'(e.woke_count));
        if (out_ch.tick_total !== e.tick_total)
          report("tick_total", out_ch.tick_total, e.tick_total);
        wakes_seen += int'(e.woke_count);
        switches_seen += int'(e.switch_now);
      end
      beats_seen++;
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    op_row_t dir_rows[$];
    logic [7:0] slices [4];
    errors = 0;
    idle_cycles = 0;
    ops_sent = 0;
    beats_seen = 0;
    wakes_seen = 0;
    switches_seen = 0;
    gap_pct = 0;
    stall_pct = 0;
    shadow_reset();

    // Directed rows; typed results hold straight after reset and at the edges.
    dir_rows.push_back(mk_typed(KIND_RESCHED, 4'd0, 5'd0, 0, 4'd0, 5'd0, 1, 32'd0));
    dir_rows.push_back(mk_typed(KIND_TICK, 4'd0, 5'd0, 0, 4'd0, 5'd0, 1, 32'd1));
    dir_rows.push_back(mk_typed(KIND_READY, 4'd5, 5'd31, 0, 4'd0, 5'd31, 0, 32'd1));
    dir_rows.push_back(mk_typed(KIND_READY, 4'd15, 5'd0, 0, 4'd0, 5'd0, 0, 32'd1));
    // Readying a task that is already ready does nothing.
    dir_rows.push_back(mk_typed(KIND_READY, 4'd5, 5'd3, 0, 4'd0, 5'd0, 0, 32'd1));
    dir_rows.push_back(mk_typed(KIND_RESCHED, 4'd0, 5'd0, 1, 4'd15, 5'd0, 0, 32'd1));
    // Unready at the wrong priority is ignored.
    dir_rows.push_back(mk(KIND_UNREADY, 4'd15, 5'd1, '0));
    dir_rows.push_back(mk(KIND_UNREADY, 4'd15, 5'd0, '0));
    // Zero delay counts as one tick.
    dir_rows.push_back(mk(KIND_DELAY, 4'd15, 5'd0, 32'd0));
    dir_rows.push_back(mk(KIND_TICK, 4'd0, 5'd0, '0));
    // Re-delay reloads the countdown and keeps the list place.
    dir_rows.push_back(mk(KIND_DELAY, 4'd5, 5'd0, 32'hFFFF_FFFF));
    dir_rows.push_back(mk(KIND_DELAY, 4'd5, 5'd0, 32'd2));
    dir_rows.push_back(mk(KIND_CANCEL, 4'd5, 5'd0, '0));
    dir_rows.push_back(mk(KIND_CANCEL, 4'd5, 5'd0, '0));
    // Scheduling while locked does nothing; the last unlock schedules.
    dir_rows.push_back(mk(KIND_LOCK, 4'd0, 5'd0, '0));
    dir_rows.push_back(mk(KIND_LOCK, 4'd0, 5'd0, '0));
    dir_rows.push_back(mk(KIND_RESCHED, 4'd0, 5'd0, '0));
    dir_rows.push_back(mk(KIND_UNLOCK, 4'd0, 5'd0, '0));
    dir_rows.push_back(mk(KIND_UNLOCK, 4'd0, 5'd0, '0));
    dir_rows.push_back(mk(KIND_UNLOCK, 4'd0, 5'd0, '0));
    dir_rows.push_back(mk(KIND_READY, 4'd0, 5'd0, '0));
    dir_rows.push_back(mk(KIND_READY, 4'd10, 5'd0, '0));
    // Waking a task that is still ready counts it without queueing it twice.
    dir_rows.push_back(mk(KIND_DELAY, 4'd0, 5'd0, 32'd1));
    dir_rows.push_back(mk(KIND_TICK, 4'd0, 5'd0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_op(dir_rows[i]);

    // Lock saturation at its top, then unwind past zero.
    for (int i = 0; i < 258; i++) send_op(mk(KIND_LOCK, 4'd0, 5'd0, '0));
    for (int i = 0; i < 257; i++) send_op(mk(KIND_UNLOCK, 4'd0, 5'd0, '0));

    slices[0] = 8'd1;
    slices[1] = 8'd255;
    slices[2] = 8'($urandom_range(9, 2));
    slices[3] = 8'd3;
    for (int ph = 0; ph < 4; ph++) begin
      write_slice(slices[ph]);
      gap_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 49 : 38) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 49 : 38) : 0;
      for (int i = 0; i < PHASE_OPS; i++) send_op(random_op());
    end
    write_slice(8'd0);
    gap_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 40; i++) send_op(mk(KIND_TICK, 4'd0, 5'd0, '0));

    settle();
    repeat (50) @(posedge clk);
    $display("sent %0d operations over five slice settings and four idling mixes",
             ops_sent);
    $display("checked %0d result beats, %0d wakes, %0d task switches",
             beats_seen, wakes_seen, switches_seen);
    if (errors == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, results_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
